>>> rtl/sfd_pkg.sv
package sfd_pkg;

  localparam logic [7:0] HeaderByte = 8'h55;
  localparam logic [7:0] TypeLow    = 8'h50;
  localparam logic [7:0] TypeHigh   = 8'h58;
  localparam int unsigned FrameLen  = 11;
  localparam int unsigned CheckPos  = 10;

  typedef logic [3:0] pos_t;

  localparam pos_t PosHeader = pos_t'(0);
  localparam pos_t PosType   = pos_t'(1);
  localparam pos_t PosCheck  = pos_t'(CheckPos);

  // one result word
  typedef struct packed {
    logic        frame_valid;
    logic        checksum_error;
    logic [7:0]  frame_type;
    logic        type_known;
    logic [63:0] payload;
  } res_t;

endpackage

>>> rtl/sfd_parse.sv
module sfd_parse
  import sfd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       adv_i,
  input  logic [7:0] byte_i,
  output res_t       res_o
);

  pos_t        pos_q, pos_d, pos;
  logic [7:0]  sum_q, sum_d;
  logic [7:0]  type_q, type_d;
  logic [63:0] pay_q, pay_d;

  always_comb begin
    // out-of-range position behaves as header position
    pos    = (pos_q > PosCheck) ? PosHeader : pos_q;
    pos_d  = pos_q;
    sum_d  = sum_q;
    type_d = type_q;
    pay_d  = pay_q;
    res_o  = '0;
    priority if (pos == PosHeader) begin
      if (byte_i == HeaderByte) begin
        sum_d = byte_i;
        pos_d = PosType;
      end else begin
        pos_d = PosHeader;
      end
    end else if (pos < PosCheck) begin
      sum_d = sum_q + byte_i;
      if (pos == PosType) begin
        type_d = byte_i;
      end else begin
        pay_d = {byte_i, pay_q[63:8]};
      end
      pos_d = pos + pos_t'(1);
    end else begin
      if (sum_q == byte_i) begin
        res_o.frame_valid = 1'b1;
        res_o.frame_type  = type_q;
        res_o.type_known  = (type_q >= TypeLow) && (type_q <= TypeHigh);
        res_o.payload     = pay_q;
      end else begin
        res_o.checksum_error = 1'b1;
      end
      pos_d = PosHeader;
      sum_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= PosHeader;
      sum_q  <= '0;
      type_q <= '0;
      pay_q  <= '0;
    end else if (adv_i) begin
      pos_q  <= pos_d;
      sum_q  <= sum_d;
      type_q <= type_d;
      pay_q  <= pay_d;
    end
  end

endmodule

>>> rtl/sensor_frame_deframer.sv
// sensor frame deframer: turns a serial byte stream into checked 11-byte frames
// input channel: in_valid_i / in_stall_o carry one received byte per word
// (rx_byte_i); a byte is taken at a clock edge with valid high and stall low
// output channel: out_valid_o / out_stall_i carry one result word for every
// byte taken; frame_valid_o marks a frame with good checksum, checksum_error_o
// a frame whose checksum byte mismatched, otherwise both flags are low and
// frame_type_o, type_known_o and payload_o are zero
// a frame is header 0x55, type byte, eight payload bytes (first one lands in
// payload_o[7:0]) and an additive modulo-256 checksum over the first ten bytes
// path: a taken byte sits in the input register, then the parse logic writes its
// result into the result register once that register is free or draining
// throughput: one byte per cycle without receiver stall, set by position/sum update
// stall: while the receiver stalls, the result register holds; the input register
// takes one more byte only if it is empty, and once it is full in_stall_o rises
// reset (rst_ni low, asynchronous): both registers empty, parser waits for a
// header byte, running sum and held frame fields cleared
module sensor_frame_deframer
  import sfd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        frame_valid_o,
  output logic        checksum_error_o,
  output logic [7:0]  frame_type_o,
  output logic        type_known_o,
  output logic [63:0] payload_o
);

  // input register
  logic       in_vld_q, in_vld_d;
  logic [7:0] byte_q;
  // result register
  logic       res_vld_q, res_vld_d;
  res_t       res_q, res_d;

  logic in_take;
  logic adv;

  // byte moves through the parser when the result register is free or draining
  assign adv     = in_vld_q && (!res_vld_q || !out_stall_i);
  assign in_take = in_valid_i && !in_stall_o;

  // input register is full and cannot move on
  assign in_stall_o = in_vld_q && !adv;

  sfd_parse u_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .byte_i (byte_q),
    .res_o  (res_d)
  );

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_take) begin
      in_vld_d = 1'b1;
    end else if (adv) begin
      in_vld_d = 1'b0;
    end
    res_vld_d = res_vld_q;
    if (adv) begin
      res_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      res_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      res_vld_q <= res_vld_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      byte_q <= rx_byte_i;
    end
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = res_vld_q;
  assign frame_valid_o    = res_q.frame_valid;
  assign checksum_error_o = res_q.checksum_error;
  assign frame_type_o     = res_q.frame_type;
  assign type_known_o     = res_q.type_known;
  assign payload_o        = res_q.payload;

`ifndef ASSERT_OFF
  // good frame and checksum error are exclusive
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(frame_valid_o && checksum_error_o))
    else $error("frame_valid and checksum_error both set");

  // without a good frame the result fields read zero
  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !frame_valid_o) |->
      (frame_type_o == 8'h00 && !type_known_o && payload_o == 64'h0))
    else $error("result fields not zero without a good frame");

  // type_known agrees with the reported type
  a_type_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_valid_o) |->
      (type_known_o == ((frame_type_o >= TypeLow) && (frame_type_o <= TypeHigh))))
    else $error("type_known disagrees with frame_type");

  // input stalls only while a result is held back by the receiver
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without output backpressure");
`endif

endmodule

>>> dv/sensor_frame_deframer_test.sv
module sensor_frame_deframer_test
  import sfd_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  rx_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        frame_valid_o;
  logic        checksum_error_o;
  logic [7:0]  frame_type_o;
  logic        type_known_o;
  logic [63:0] payload_o;

  sensor_frame_deframer u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .rx_byte_i        (rx_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .frame_valid_o    (frame_valid_o),
    .checksum_error_o (checksum_error_o),
    .frame_type_o     (frame_type_o),
    .type_known_o     (type_known_o),
    .payload_o        (payload_o)
  );

  // result words still owed by the block, oldest first
  res_t        pending_words[$];
  int unsigned mismatch_count;

  // idle chances in percent, and a forced receiver hold-off in cycles
  int unsigned sender_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_cycles;

  // shadow of the frame parser state
  pos_t        frame_pos;
  logic [7:0]  frame_sum;
  logic [7:0]  frame_kind;
  logic [63:0] frame_body;

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // run limit: far above the slowest legal run
  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // parse one byte and return the word the block owes for it
  function automatic res_t deframe_byte(input logic [7:0] rx);
    res_t word;
    pos_t pos;
    word = '0;
    pos  = frame_pos;
    // an out-of-range position behaves like waiting for a header
    if (pos > PosCheck) pos = PosHeader;
    if (pos == PosHeader) begin
      // anything but the header is dropped here
      if (rx == HeaderByte) begin
        frame_sum = rx;
        frame_pos = PosType;
      end else begin
        frame_pos = PosHeader;
      end
    end else if (pos < PosCheck) begin
      // a header value inside the frame is plain data
      frame_sum = frame_sum + rx;
      if (pos == PosType) frame_kind = rx;
      else frame_body = {rx, frame_body[63:8]};
      frame_pos = pos + 1'b1;
    end else begin
      if (frame_sum == rx) begin
        word.frame_valid = 1'b1;
        word.frame_type  = frame_kind;
        word.type_known  = (frame_kind >= TypeLow) && (frame_kind <= TypeHigh);
        word.payload     = frame_body;
      end else begin
        // bad checksum: whole frame discarded, no search for a later header
        word.checksum_error = 1'b1;
      end
      frame_pos = PosHeader;
      frame_sum = '0;
    end
    return word;
  endfunction

  // offer one byte, hold it until taken, then log what it should produce
  task automatic send_byte(input logic [7:0] rx);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= rx;
    do @(posedge clk_i); while (in_stall_o);
    // valid stays up; the next send either replaces the byte or drops valid
    pending_words.push_back(deframe_byte(rx));
  endtask

  // send the first n_sent bytes of a frame; sum_skew of zero gives a good checksum
  task automatic send_frame(input logic [7:0] ftype, input logic [63:0] body,
                            input logic [7:0] sum_skew, input int unsigned n_sent);
    logic [7:0] frame_bytes [FrameLen];
    logic [7:0] sum;
    frame_bytes[0] = HeaderByte;
    frame_bytes[1] = ftype;
    for (int i = 0; i < 8; i++) frame_bytes[2 + i] = body[8 * i +: 8];
    sum = '0;
    for (int i = 0; i < CheckPos; i++) sum = sum + frame_bytes[i];
    frame_bytes[CheckPos] = sum + sum_skew;
    for (int i = 0; i < n_sent; i++) send_byte(frame_bytes[i]);
  endtask

  // sender goes quiet until every owed word has come out
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
  endtask

  // dropped bytes, type range edges, header value in payload, bad checksum
  task automatic test_header_and_checksum();
    sender_idle_pct = 0;
    recv_idle_pct   = 0;
    send_byte(8'h00);
    send_byte(8'hff);
    send_frame(TypeHigh, 64'h00ff_55aa_0000_ffff, 8'h00, FrameLen);
    // bad checksum, then a header value inside the discarded frame
    send_frame(TypeLow - 8'd1, 64'h5555_0000_ff00_0055, 8'h01, FrameLen);
    drain_results();
  endtask

  // mostly well-formed frames with random content, some bad checksums, noise and cut frames
  task automatic test_random_stream(input int unsigned send_pct, input int unsigned recv_pct,
                                    input int unsigned n_bytes);
    int unsigned sent;
    int unsigned pick;
    int unsigned cut;
    logic [7:0]  ftype;
    sender_idle_pct = send_pct;
    recv_idle_pct   = recv_pct;
    sent = 0;
    while (sent < n_bytes) begin
      pick = $urandom_range(19);
      // types near the known range half the time
      if ($urandom_range(1)) ftype = 8'($urandom_range(TypeHigh + 1, TypeLow - 1));
      else ftype = 8'($urandom_range(255));
      if (pick == 0) begin
        // line noise, may open a frame by chance
        repeat ($urandom_range(4, 1)) send_byte(8'($urandom_range(255)));
      end else if (pick == 1) begin
        // cut frame: the following bytes are swallowed as its data
        cut = $urandom_range(FrameLen - 1, 2);
        send_frame(ftype, {$urandom(), $urandom()}, 8'h00, cut);
        sent += cut;
      end else if (pick < 6) begin
        send_frame(ftype, {$urandom(), $urandom()}, 8'($urandom_range(255, 1)), FrameLen);
        sent += FrameLen;
      end else begin
        send_frame(ftype, {$urandom(), $urandom()}, 8'h00, FrameLen);
        sent += FrameLen;
      end
    end
    drain_results();
  endtask

  // long receiver hold-off while the sender keeps offering, so the input stalls
  task automatic test_backpressure();
    sender_idle_pct = 0;
    recv_idle_pct   = 0;
    hold_cycles     = 40;
    send_frame(TypeLow, {$urandom(), $urandom()}, 8'h00, FrameLen);
    send_frame(8'($urandom_range(255)), {$urandom(), $urandom()}, 8'h00, FrameLen);
    drain_results();
  endtask

  // receiver stall: forced hold-off first, random otherwise
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles--;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endtask

  // every taken result word against the oldest owed one
  always @(posedge clk_i) begin : check_words
    res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_words.size() == 0) begin
        $error("result word with nothing owed");
        mismatch_count++;
      end else begin
        want = pending_words.pop_front();
        check_field("frame_valid", 64'(want.frame_valid), 64'(frame_valid_o));
        check_field("checksum_error", 64'(want.checksum_error), 64'(checksum_error_o));
        check_field("frame_type", 64'(want.frame_type), 64'(frame_type_o));
        check_field("type_known", 64'(want.type_known), 64'(type_known_o));
        check_field("payload", want.payload, payload_o);
      end
    end
  end

  initial begin
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    rx_byte_i       = '0;
    out_stall_i     = 1'b0;
    mismatch_count  = 0;
    sender_idle_pct = 0;
    recv_idle_pct   = 0;
    hold_cycles     = 0;
    frame_pos       = PosHeader;
    frame_sum       = '0;
    frame_kind      = '0;
    frame_body      = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_header_and_checksum();
    test_random_stream(36, 70, 300);
    test_random_stream(70, 36, 300);
    test_random_stream(0, 0, 300);
    test_backpressure();

    // let the two-stage pipe settle before the verdict
    repeat (6) @(posedge clk_i);
    if (mismatch_count == 0 && pending_words.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
